// ===== hdl/sovi_pkg.sv =====
package sovi_pkg;

  // Fixed sizes of the item and of the result.
  localparam int COMP_W      = 32;
  localparam int NUM_COMP    = 12;
  localparam int VAL_W       = 64;
  localparam int ACC_W       = 128;
  localparam int ROOT_W      = 64;
  localparam int SQRT_STEPS  = 64;
  localparam int DIV_STEPS   = 128;
  localparam int QUEUE_DEPTH = 2;

  // Quantity codes in the order in which the results leave the block.
  localparam logic [3:0] Q_RADIUS = 4'd0;
  localparam logic [3:0] Q_RADIAL = 4'd1;
  localparam logic [3:0] Q_PP     = 4'd2;
  localparam logic [3:0] Q_XS1    = 4'd3;
  localparam logic [3:0] Q_XS2    = 4'd4;
  localparam logic [3:0] Q_PS1    = 4'd5;
  localparam logic [3:0] Q_PS2    = 4'd6;
  localparam logic [3:0] Q_S1S1   = 4'd7;
  localparam logic [3:0] Q_S1S2   = 4'd8;
  localparam logic [3:0] Q_S2S2   = 4'd9;
  localparam logic [3:0] Q_LX     = 4'd10;
  localparam logic [3:0] Q_LY     = 4'd11;
  localparam logic [3:0] Q_LZ     = 4'd12;
  localparam logic [3:0] Q_LS1    = 4'd13;
  localparam logic [3:0] Q_LS2    = 4'd14;

  // Vector codes; a vector occupies three consecutive components.
  localparam logic [1:0] V_POS = 2'd0;
  localparam logic [1:0] V_MOM = 2'd1;
  localparam logic [1:0] V_S1  = 2'd2;
  localparam logic [1:0] V_S2  = 2'd3;

  // Component indexes used by the cross product.
  localparam logic [3:0] C_POS_X = 4'd0;
  localparam logic [3:0] C_POS_Y = 4'd1;
  localparam logic [3:0] C_POS_Z = 4'd2;
  localparam logic [3:0] C_MOM_X = 4'd3;
  localparam logic [3:0] C_MOM_Y = 4'd4;
  localparam logic [3:0] C_MOM_Z = 4'd5;

  // Operand codes at and above this one select halves of a stored L component.
  localparam logic [4:0] A_L_BASE = 5'd12;

  typedef struct packed {
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] mom_x;
    logic signed [COMP_W-1:0] mom_y;
    logic signed [COMP_W-1:0] mom_z;
    logic signed [COMP_W-1:0] spin_one_x;
    logic signed [COMP_W-1:0] spin_one_y;
    logic signed [COMP_W-1:0] spin_one_z;
    logic signed [COMP_W-1:0] spin_two_x;
    logic signed [COMP_W-1:0] spin_two_y;
    logic signed [COMP_W-1:0] spin_two_z;
  } sovi_in_t;

  typedef struct packed {
    logic [3:0]              quantity;
    logic signed [VAL_W-1:0] value;
    logic                    zero_radius;
    logic                    last;
  } sovi_out_t;

  // Classified item as it waits in the queue.
  typedef struct packed {
    logic                              zero;
    logic [NUM_COMP-1:0][COMP_W-1:0]   comp;
  } sovi_item_t;

  // One product step of the sequencer.
  typedef struct packed {
    logic [4:0] a_sel;
    logic [3:0] b_sel;
    logic       neg;
    logic       shl;
    logic       fin;
  } sovi_op_t;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic [ACC_W-1:0]  n;
    logic [ROOT_W-1:0] d;
  } sovi_rd_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] result;
  } sovi_rd_stat_t;

  // Saturate a 128-bit two's complement value to 64 bits.
  function automatic logic [VAL_W-1:0] sat64(input logic [ACC_W-1:0] v);
    logic [VAL_W-1:0] r;
    if ((v[ACC_W-1:VAL_W-1] == '0) || (v[ACC_W-1:VAL_W-1] == '1)) begin
      r = v[VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Product step i of quantity q: operands, sign, shift and end of the sum.
  function automatic sovi_op_t step_op(input logic [3:0] q, input logic [2:0] i);
    sovi_op_t   op;
    logic [1:0] va;
    logic [1:0] vb;
    logic       is_dot;
    op     = '0;
    va     = V_POS;
    vb     = V_POS;
    is_dot = 1'b1;
    case (q)
      Q_RADIUS: begin va = V_POS; vb = V_POS; end
      Q_RADIAL: begin va = V_POS; vb = V_MOM; end
      Q_PP:     begin va = V_MOM; vb = V_MOM; end
      Q_XS1:    begin va = V_POS; vb = V_S1;  end
      Q_XS2:    begin va = V_POS; vb = V_S2;  end
      Q_PS1:    begin va = V_MOM; vb = V_S1;  end
      Q_PS2:    begin va = V_MOM; vb = V_S2;  end
      Q_S1S1:   begin va = V_S1;  vb = V_S1;  end
      Q_S1S2:   begin va = V_S1;  vb = V_S2;  end
      Q_S2S2:   begin va = V_S2;  vb = V_S2;  end
      Q_LX: begin
        is_dot = 1'b0;
        op.a_sel = {1'b0, (i[0] ? C_POS_Z : C_POS_Y)};
        op.b_sel = i[0] ? C_MOM_Y : C_MOM_Z;
        op.neg   = i[0];
        op.fin   = i[0];
      end
      Q_LY: begin
        is_dot = 1'b0;
        op.a_sel = {1'b0, (i[0] ? C_POS_X : C_POS_Z)};
        op.b_sel = i[0] ? C_MOM_Z : C_MOM_X;
        op.neg   = i[0];
        op.fin   = i[0];
      end
      Q_LZ: begin
        is_dot = 1'b0;
        op.a_sel = {1'b0, (i[0] ? C_POS_Y : C_POS_X)};
        op.b_sel = i[0] ? C_MOM_X : C_MOM_Y;
        op.neg   = i[0];
        op.fin   = i[0];
      end
      Q_LS1, Q_LS2: begin
        // Low half unsigned, high half signed and shifted up by 32.
        is_dot = 1'b0;
        vb       = (q == Q_LS1) ? V_S1 : V_S2;
        op.a_sel = A_L_BASE + {2'b0, i[2:1], 1'b0} + {4'b0, i[0]};
        op.b_sel = {vb, 2'b0} - {2'b0, vb} + {2'b0, i[2:1]};
        op.shl   = i[0];
        op.fin   = (i == 3'd5);
      end
      default: begin
        is_dot = 1'b0;
        op.fin = 1'b1;
      end
    endcase
    if (is_dot) begin
      op.a_sel = {1'b0, {va, 2'b0} - {2'b0, va} + {1'b0, i}};
      op.b_sel = {vb, 2'b0} - {2'b0, vb} + {1'b0, i};
      op.fin   = (i == 3'd2);
    end
    return op;
  endfunction

endpackage

// ===== hdl/spin_orbit_vector_invariants.sv =====
// Takes one request of four 3-vectors (position, momentum, two spins) and
// returns fifteen results in fixed order: radius, radial momentum, eight dot
// products, the three components of L = x cross p, then L.s1 and L.s2, each
// signed Q31.32; all but the radius are saturated. An item passes 48
// products through the single 33x33 multiplier, a 64-step square root and
// a 128-step divide in the shared root/divide unit, and a finish and an
// output step for each result; output stalls can hold it. A two-entry
// queue behind the input register lets up to three further requests be taken
// while one is being worked on.
module spin_orbit_vector_invariants #(
  parameter int IN_WIDTH  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sovi_pkg::sovi_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sovi_pkg::sovi_out_t out_o
);
  import sovi_pkg::*;

  logic          push_valid;
  sovi_item_t    push_item;
  logic          queue_full;
  logic          pop;
  logic          pop_valid;
  sovi_item_t    pop_item;
  sovi_rd_req_t  rd_req;
  sovi_rd_stat_t rd_stat;

  // Front: accept and classify.
  sovi_front #(
    .IN_WIDTH(IN_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_item_o (push_item),
    .push_stall_i(queue_full)
  );

  // Queue between front and back.
  sovi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item)
  );

  // Shared square root and divide unit.
  sovi_rootdiv u_rootdiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rd_req),
    .stat_o(rd_stat)
  );

  // Back: sequence the fifteen quantities.
  sovi_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(pop_valid),
    .item_i      (pop_item),
    .item_pop_o  (pop),
    .rd_req_o    (rd_req),
    .rd_stat_i   (rd_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ===== hdl/sovi_front.sv =====
module sovi_front #(
  parameter int IN_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sovi_pkg::sovi_in_t   in_i,
  output logic                 push_valid_o,
  output sovi_pkg::sovi_item_t push_item_o,
  input  logic                 push_stall_i
);
  import sovi_pkg::*;

  localparam int EXT_SH = COMP_W - IN_WIDTH;

  logic [NUM_COMP-1:0][COMP_W-1:0] raw;
  sovi_item_t                      cls;
  logic                            valid_q;
  sovi_item_t                      item_q;
  logic                            accept;

  // Sign-extend each component from IN_WIDTH bits and flag a zero position.
  always_comb begin
    raw = {in_i.spin_two_z, in_i.spin_two_y, in_i.spin_two_x,
           in_i.spin_one_z, in_i.spin_one_y, in_i.spin_one_x,
           in_i.mom_z, in_i.mom_y, in_i.mom_x,
           in_i.pos_z, in_i.pos_y, in_i.pos_x};
    for (int k = 0; k < NUM_COMP; k++) begin
      cls.comp[k] = COMP_W'(($signed(raw[k]) <<< EXT_SH) >>> EXT_SH);
    end
    cls.zero = (cls.comp[C_POS_X] == '0) && (cls.comp[C_POS_Y] == '0) &&
               (cls.comp[C_POS_Z] == '0);
  end

  assign in_stall_o   = valid_q && push_stall_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // Input register; it empties into the queue whenever the queue has room.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        item_q  <= cls;
        valid_q <= 1'b1;
      end else if (!push_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/sovi_queue.sv =====
module sovi_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  sovi_pkg::sovi_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 pop_valid_o,
  output sovi_pkg::sovi_item_t pop_item_o
);
  import sovi_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  sovi_item_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [PTR_W:0]     count_q;
  logic               push;
  logic               pop;

  assign full_o      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_i && pop_valid_o;

  // Storage is written at the tail only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== hdl/sovi_rootdiv.sv =====
module sovi_rootdiv (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sovi_pkg::sovi_rd_req_t req_i,
  output sovi_pkg::sovi_rd_stat_t stat_o
);
  import sovi_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic              is_div_q;
  logic [6:0]        cnt_q;
  logic [ACC_W-1:0]  n_q;
  logic [ACC_W-1:0]  res_q;
  logic [ROOT_W-1:0] d_q;
  logic [66:0]       rem_q;

  logic [66:0]       sq_sh;
  logic [66:0]       sq_trial;
  logic              sq_ge;
  logic [64:0]       dv_sh;
  logic              dv_ge;
  logic [64:0]       dv_rem;

  // One root digit or one quotient bit per cycle.
  always_comb begin
    sq_sh    = {rem_q[64:0], n_q[ACC_W-1 -: 2]};
    sq_trial = {res_q[64:0], 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    dv_sh    = {rem_q[63:0], n_q[ACC_W-1]};
    dv_ge    = (dv_sh >= {1'b0, d_q});
    dv_rem   = dv_ge ? (dv_sh - {1'b0, d_q}) : dv_sh;
  end

  assign stat_o.busy   = busy_q;
  assign stat_o.done   = done_q;
  assign stat_o.result = res_q;

  // Sequencer of the shared unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        is_div_q <= req_i.is_div;
        n_q      <= req_i.n;
        d_q      <= req_i.d;
        rem_q    <= '0;
        res_q    <= '0;
        cnt_q    <= req_i.is_div ? 7'(DIV_STEPS-1) : 7'(SQRT_STEPS-1);
      end else if (busy_q) begin
        if (is_div_q) begin
          rem_q <= {3'b0, dv_rem[63:0]};
          res_q <= {res_q[ACC_W-2:0], dv_ge};
          n_q   <= {n_q[ACC_W-2:0], 1'b0};
        end else begin
          rem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          res_q <= {res_q[ACC_W-2:0], sq_ge};
          n_q   <= {n_q[ACC_W-3:0], 2'b0};
        end
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/sovi_back.sv =====
module sovi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  sovi_pkg::sovi_item_t    item_i,
  output logic                    item_pop_o,
  output sovi_pkg::sovi_rd_req_t  rd_req_o,
  input  sovi_pkg::sovi_rd_stat_t rd_stat_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sovi_pkg::sovi_out_t     out_o
);
  import sovi_pkg::*;

  localparam int FRAC2 = 2 * FRAC_BITS;
  localparam int FRAC3 = 3 * FRAC_BITS;
  localparam int SH2L  = (FRAC2 < 32) ? (32 - FRAC2) : 0;
  localparam int SH2R  = (FRAC2 > 32) ? (FRAC2 - 32) : 0;
  localparam int SH3L  = (FRAC3 < 32) ? (32 - FRAC3) : 0;
  localparam int SH3R  = (FRAC3 > 32) ? (FRAC3 - 32) : 0;
  localparam int NSH   = 64 - FRAC2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_FIN,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e            state_q;
  sovi_item_t        item_q;
  logic [3:0]        q_q;
  logic [2:0]        i_q;
  logic [ACC_W-1:0]  acc_q;
  logic [65:0]       prod_q;
  logic [64:0]       l_q [3];
  logic [ROOT_W-1:0] root_q;
  logic [VAL_W-1:0]  val_q;
  logic              neg_q;
  logic              out_valid_q;
  sovi_out_t         out_q;

  sovi_op_t          op;
  logic [4:0]        l_sel;
  logic signed [32:0] a_opnd;
  logic signed [32:0] b_opnd;
  logic signed [65:0] product;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]  scaled;
  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  quot;
  logic [VAL_W-1:0]  fin_value;
  logic [VAL_W-1:0]  div_value;
  logic              is_l;
  logic [1:0]        l_idx;
  logic              out_free;
  logic              emit;

  // Operand selection and the one shared multiplier.
  always_comb begin
    op    = step_op(q_q, i_q);
    l_sel = op.a_sel - A_L_BASE;
    if (op.a_sel < A_L_BASE) begin
      a_opnd = {item_q.comp[op.a_sel[3:0]][COMP_W-1], item_q.comp[op.a_sel[3:0]]};
    end else if (l_sel[0]) begin
      a_opnd = l_q[l_sel[2:1]][64:32];
    end else begin
      a_opnd = {1'b0, l_q[l_sel[2:1]][31:0]};
    end
    b_opnd  = {item_q.comp[op.b_sel][COMP_W-1], item_q.comp[op.b_sel]};
    product = a_opnd * b_opnd;
  end

  // Accumulation, scaling, saturation and the divide request.
  always_comb begin
    addend = {{(ACC_W-66){prod_q[65]}}, prod_q};
    if (op.shl) begin
      addend = addend << 32;
    end
    acc_next = op.neg ? (acc_q - addend) : (acc_q + addend);
    if ((q_q == Q_LS1) || (q_q == Q_LS2)) begin
      scaled = ACC_W'(($signed(acc_q) <<< SH3L) >>> SH3R);
    end else begin
      scaled = ACC_W'(($signed(acc_q) <<< SH2L) >>> SH2R);
    end
    fin_value = sat64(scaled);
    mag       = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
    quot      = neg_q ? (~rd_stat_i.result + 1'b1) : rd_stat_i.result;
    div_value = sat64(quot);
    is_l      = (q_q >= Q_LX) && (q_q <= Q_LZ);
    l_idx     = 2'(q_q - Q_LX);
    out_free  = !out_valid_q || !out_stall_i;
    emit      = (state_q == S_EMIT) && out_free;

    rd_req_o.start  = (state_q == S_FIN) &&
                      ((q_q == Q_RADIUS) || ((q_q == Q_RADIAL) && !item_q.zero));
    rd_req_o.is_div = (q_q == Q_RADIAL);
    rd_req_o.n      = ((q_q == Q_RADIAL) ? mag : acc_q) << NSH;
    rd_req_o.d      = root_q;
  end

  assign item_pop_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Sequencer over the fifteen quantities and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            item_q  <= item_i;
            q_q     <= Q_RADIUS;
            i_q     <= '0;
            acc_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= product;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_next;
          if (op.fin) begin
            state_q <= S_FIN;
          end else begin
            i_q     <= i_q + 3'd1;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          neg_q <= acc_q[ACC_W-1];
          if (q_q == Q_RADIUS) begin
            state_q <= S_WAIT;
          end else if (q_q == Q_RADIAL) begin
            if (item_q.zero) begin
              val_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_WAIT;
            end
          end else begin
            val_q <= fin_value;
            if (is_l) begin
              l_q[l_idx] <= acc_q[64:0];
            end
            state_q <= S_EMIT;
          end
        end
        S_WAIT: begin
          if (rd_stat_i.done) begin
            if (q_q == Q_RADIUS) begin
              root_q <= rd_stat_i.result[ROOT_W-1:0];
              val_q  <= rd_stat_i.result[VAL_W-1:0];
            end else begin
              val_q <= div_value;
            end
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_q.quantity    <= q_q;
            out_q.value       <= val_q;
            out_q.zero_radius <= item_q.zero;
            out_q.last        <= (q_q == Q_LS2);
            if (q_q == Q_LS2) begin
              state_q <= S_IDLE;
            end else begin
              q_q     <= q_q + 4'd1;
              i_q     <= '0;
              acc_q   <= '0;
              state_q <= S_MUL;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The shared unit is never restarted while it works.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req_o.start |-> !rd_stat_i.busy)
    else $error("root/divide unit started while busy");

  // The end marker goes with the final quantity only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.quantity == Q_LS2)))
    else $error("last flag on the wrong quantity");

  // A zero radius and the zero flag agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.quantity == Q_RADIUS)) |->
      ((out_q.value == '0) == out_q.zero_radius))
    else $error("radius and zero flag disagree");

  // Radial momentum of a zero position is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.quantity == Q_RADIAL) && out_q.zero_radius) |->
      (out_q.value == '0))
    else $error("radial momentum not zero for zero radius");
`endif

endmodule
